// ----- design/tridiagonal_solver_macros.svh -----
// Assertion macros shared by the solver RTL
`ifndef TRIDIAGONAL_SOLVER_MACROS_SVH
`define TRIDIAGONAL_SOLVER_MACROS_SVH

// Property must hold at every clock edge outside reset
`define TDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define TDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tds_pkg.sv -----
// Package with types, constants and arithmetic helpers for the tridiagonal solver
package tds_pkg;

  localparam int unsigned MaxRowsDef  = 64;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned IdxW        = 6;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FDIV,
    ST_FMUL,
    ST_FSUB,
    ST_BREAD,
    ST_BWAIT,
    ST_BMUL,
    ST_BSUB,
    ST_BDIV,
    ST_BOUT
  } state_e;

  function automatic data_t sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction

endpackage

// ----- design/tds_ram.sv -----
// Generic single-port-write, registered-read RAM
module tds_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- design/tds_div.sv -----
// Iterative restoring divider: sat((num << FracBits) / den), truncated toward zero
module tds_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tds_pkg::data_t       num_i,
  input  tds_pkg::data_t       den_i,
  output logic                 done_o,
  output tds_pkg::data_t       quot_o,
  output logic                 zero_o
);
  import tds_pkg::*;

  localparam int unsigned NumW = DataW + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] dvd_q, dvd_d;
  logic [DataW:0]  rem_q, rem_d;
  logic [DataW-1:0] dsr_q;
  logic            neg_q, busy_q, zero_q;
  logic [CntW-1:0] cnt_q;
  logic [DataW:0]  trial;
  logic [DataW:0]  shifted;
  logic [NumW:0]   qmag;
  logic signed [65:0] qs;

  assign shifted = {rem_q[DataW-1:0], dvd_q[NumW-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    rem_d = trial[DataW] ? shifted : trial;
    dvd_d = {dvd_q[NumW-2:0], ~trial[DataW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= (den_i != '0);
        done_o <= (den_i == '0);
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {(num_i[DataW-1] ? DataW'(-num_i) : DataW'(num_i)), {FracBits{1'b0}}};
      dsr_q  <= den_i[DataW-1] ? DataW'(-den_i) : DataW'(den_i);
      rem_q  <= '0;
      neg_q  <= num_i[DataW-1] ^ den_i[DataW-1];
      zero_q <= (den_i == '0);
      quot_o <= num_i[DataW-1] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (cnt_q == CntW'(1)) quot_o <= sat64(qs);
    end
  end

  assign qmag = {1'b0, dvd_d};
  assign qs   = neg_q ? -$signed(66'(qmag)) : $signed(66'(qmag));
  assign zero_o = zero_q;
endmodule

// ----- design/tridiagonal_solver.sv -----
// Tridiagonal solver: Thomas algorithm over RAM-held rows, Q-format fixed point
// Usage:
//  Input channel carries one matrix row per item (lower, diag, upper, rhs, last_row),
//  rows from row 0 upward. Output channel carries one solution element per item.
//  Each accepted row after row 0 runs forward elimination: one iterative
//  division and two multiplies, in Q16.16 with the default FRAC_BITS.
//  A row marked last is eliminated, then back substitution emits n elements from
//  row n-1 down to row 0; each element costs one RAM read, a multiply, a subtract
//  and a division.
//  The divider sets the rate in both sweeps.
//  in_stall_o is high while a row or a back sweep is in progress.
//  Row 0's element carries last_result_o; pivot_zero_o is sticky within a solve.
//  A row beyond MAX_ROWS is dropped; a last-marked one still triggers the sweep.
//  When out_stall_i is high the current element holds in the output register and
//  the sweep waits.
//  Reset clears the control state and the run registers; the row RAMs are not
//  cleared and are only read at rows written in the current solve.
module tridiagonal_solver #(
  parameter int unsigned MAX_ROWS  = tds_pkg::MaxRowsDef,
  parameter int unsigned FRAC_BITS = tds_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tds_pkg::data_t            lower_coef_i,
  input  tds_pkg::data_t            diag_coef_i,
  input  tds_pkg::data_t            upper_coef_i,
  input  tds_pkg::data_t            rhs_value_i,
  input  logic                      last_row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tds_pkg::IdxW-1:0]  row_index_o,
  output tds_pkg::data_t            solution_o,
  output logic                      last_result_o,
  output logic                      pivot_zero_o
);
  import tds_pkg::*;
  `include "tridiagonal_solver_macros.svh"

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned RamW = 3 * DataW;

  state_e state_q, state_d;
  logic [CW-1:0] rows_q;
  logic [AW-1:0] ridx_q;
  data_t pmd_q, pmr_q, pup_q;
  data_t in_d_q, in_u_q, in_r_q;
  logic  in_last_q, zps_q;
  data_t fac_q, p1_q, p2_q, x_q;
  logic  accept, have_room, out_load;

  logic          we;
  logic [AW-1:0] waddr;
  logic [RamW-1:0] wdata, rdata;
  data_t rd_md, rd_up, rd_mr;

  logic  div_start, div_done, div_zero;
  data_t div_num, div_den, div_q;

  logic signed [63:0] prod1, prod2;

  assign accept = in_valid_i && !in_stall_o;
  assign have_room = rows_q < CW'(MAX_ROWS);
  assign out_load = (state_q == ST_BOUT) && (!out_valid_o || !out_stall_i);

  tds_ram #(.Width(RamW), .Depth(MAX_ROWS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ridx_q),
    .rdata_o (rdata)
  );
  assign rd_md = rdata[3*DataW-1:2*DataW];
  assign rd_up = rdata[2*DataW-1:DataW];
  assign rd_mr = rdata[DataW-1:0];

  tds_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q),
    .zero_o  (div_zero)
  );

  function automatic data_t fx_round(input logic signed [63:0] p);
    logic signed [65:0] s;
    s = 66'(p >>> FRAC_BITS);
    return sat64(s);
  endfunction

  function automatic data_t fx_sub(input data_t a, input data_t b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return sat64(s);
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (have_room && rows_q != '0) state_d = ST_FDIV;
          else if (last_row_i) state_d = ST_BREAD;
        end
      end
      ST_FDIV:  if (div_done) state_d = ST_FMUL;
      ST_FMUL:  state_d = ST_FSUB;
      ST_FSUB:  state_d = in_last_q ? ST_BREAD : ST_IDLE;
      ST_BREAD: state_d = (rows_q == '0) ? ST_IDLE : ST_BWAIT;
      ST_BWAIT: state_d = ST_BMUL;
      ST_BMUL:  state_d = ST_BSUB;
      ST_BSUB:  state_d = ST_BDIV;
      ST_BDIV:  if (div_done) state_d = ST_BOUT;
      ST_BOUT: begin
        if (out_load)
          state_d = (ridx_q == '0) ? ST_IDLE : ST_BWAIT;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs to divider and RAM
  always_comb begin
    div_start = 1'b0;
    div_num   = fx_sub(rd_mr, p1_q);
    div_den   = rd_md;
    we        = 1'b0;
    waddr     = rows_q[AW-1:0];
    wdata     = {in_d_q, in_u_q, in_r_q};
    unique case (state_q)
      ST_IDLE: begin
        div_num = lower_coef_i;
        div_den = pmd_q;
        div_start = accept && have_room && rows_q != '0;
        we = accept && have_room && rows_q == '0;
        wdata = {diag_coef_i, upper_coef_i, rhs_value_i};
      end
      ST_FSUB: begin
        we = 1'b1;
        wdata = {fx_sub(in_d_q, p1_q), in_u_q, fx_sub(in_r_q, p2_q)};
      end
      ST_BSUB: div_start = 1'b1;
      default: ;
    endcase
  end

  assign prod1 = 64'(pup_q) * 64'(fac_q);
  assign prod2 = 64'(pmr_q) * 64'(fac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rows_q  <= '0;
      pmd_q   <= '0;
      pmr_q   <= '0;
      pup_q   <= '0;
      zps_q   <= 1'b0;
      ridx_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      // hold a stalled item, drop a taken one, load the next element
      out_valid_o <= out_load || (out_valid_o && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (accept && have_room && rows_q == '0) begin
            pmd_q  <= diag_coef_i;
            pmr_q  <= rhs_value_i;
            pup_q  <= upper_coef_i;
            rows_q <= rows_q + 1'b1;
          end
        end
        ST_FDIV: if (div_done && div_zero) zps_q <= 1'b1;
        ST_FSUB: begin
          pmd_q  <= fx_sub(in_d_q, p1_q);
          pmr_q  <= fx_sub(in_r_q, p2_q);
          pup_q  <= in_u_q;
          rows_q <= rows_q + 1'b1;
        end
        ST_BREAD: begin
          ridx_q <= AW'(rows_q - 1'b1);
          if (rows_q == '0) begin
            pmd_q <= '0; pmr_q <= '0; pup_q <= '0; zps_q <= 1'b0;
          end
        end
        ST_BDIV: if (div_done && div_zero) zps_q <= 1'b1;
        ST_BOUT: begin
          if (out_load) begin
            if (ridx_q == '0) begin
              rows_q <= '0;
              pmd_q <= '0; pmr_q <= '0; pup_q <= '0; zps_q <= 1'b0;
            end else begin
              ridx_q <= ridx_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_d_q <= diag_coef_i;
      in_u_q <= upper_coef_i;
      in_r_q <= rhs_value_i;
      in_last_q <= last_row_i;
    end
    if (state_q == ST_FDIV && div_done) fac_q <= div_q;
    if (state_q == ST_FMUL) begin
      p1_q <= fx_round(prod1);
      p2_q <= fx_round(prod2);
    end
    if (state_q == ST_BREAD) x_q <= '0;
    if (state_q == ST_BMUL) begin
      // top row of the sweep divides the plain modified rhs
      p1_q <= (ridx_q == AW'(rows_q - 1'b1)) ? '0 : fx_round(64'(rd_up) * 64'(x_q));
    end
    if (state_q == ST_BDIV && div_done) x_q <= div_q;
    if (out_load) begin
      row_index_o   <= IdxW'(ridx_q);
      solution_o    <= x_q;
      last_result_o <= (ridx_q == '0);
      pivot_zero_o  <= zps_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `TDS_ASSERT(a_no_accept_busy, !(accept && state_q != ST_IDLE), "item accepted while busy")
  `TDS_ASSERT(a_rows_range, rows_q <= CW'(MAX_ROWS), "row count out of range")
  `TDS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(solution_o),
    "stalled result changed")
endmodule
